### src/assert_macros.svh
// Assertion macros used by the top level of the slew limiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clock outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising edge of clock outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/mjsl_pkg.sv
// Shared types and constants of the multi-joint slew limiter.
package mjsl_pkg;

   // Transaction modes on the request channel.
   localparam logic [1:0] MODE_TICK     = 2'd0;
   localparam logic [1:0] MODE_GOAL     = 2'd1;
   localparam logic [1:0] MODE_POS_GOAL = 2'd2;
   localparam logic [1:0] MODE_VEL      = 2'd3;

   // Field widths fixed by the interface.
   localparam int unsigned JOINT_W    = 4;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned ELAPSED_W  = 24;
   localparam int unsigned MAX_STEP_W = 25;

   // Reset value of max_step, about 1.0e-3 rad in Q8.24.
   localparam logic [MAX_STEP_W-1:0] MAX_STEP_RESET = 25'd16777;

   // Control from the sequencer to the shared step unit.
   typedef struct packed {
      logic load;      // capture operands and form product or difference
      logic vel_mode;  // velocity mode when set, position mode otherwise
   } step_ctrl_type;

endpackage

### src/mjsl_step_unit.sv
// Shared two-stage arithmetic unit that computes one joint's new position.
module mjsl_step_unit (
   input  logic                                clock,
   input  mjsl_pkg::step_ctrl_type             ctrl,
   input  logic signed [mjsl_pkg::VALUE_W-1:0] pos,
   input  logic signed [mjsl_pkg::VALUE_W-1:0] goal,
   input  logic signed [mjsl_pkg::VALUE_W-1:0] vel,
   input  logic [mjsl_pkg::ELAPSED_W-1:0]      elapsed,
   input  logic [mjsl_pkg::MAX_STEP_W-1:0]     max_step,
   output logic signed [mjsl_pkg::VALUE_W-1:0] new_pos
);

   localparam logic signed [57:0] ROUND_HALF = 58'sd8388608;
   localparam logic signed [34:0] POS_MAX    = 35'sd2147483647;
   localparam logic signed [34:0] POS_MIN    = -35'sd2147483648;

   logic signed [56:0] opnd_ff, opnd_in;
   logic signed [31:0] pos_ff;
   logic               vel_mode_ff;

   logic signed [24:0] elapsed_s;
   logic signed [56:0] prod;
   logic signed [32:0] diff;
   logic signed [57:0] biased;
   logic signed [33:0] delta;
   logic signed [33:0] jump;
   logic signed [33:0] lim;
   logic signed [33:0] clamped;
   logic signed [33:0] addend;
   logic signed [34:0] sum;

   // First stage: the one multiplier in velocity mode, the goal difference otherwise.
   assign elapsed_s = signed'({1'b0, elapsed});
   assign prod      = elapsed_s * vel;
   assign diff      = {goal[31], goal} - {pos[31], pos};
   assign opnd_in   = ctrl.vel_mode ? prod : {{24{diff[32]}}, diff};

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         opnd_ff     <= opnd_in;
         pos_ff      <= pos;
         vel_mode_ff <= ctrl.vel_mode;
      end
   end

   // Velocity step: round the Q8.48 product to Q8.24, ties toward plus infinity.
   assign biased = {opnd_ff[56], opnd_ff} + ROUND_HALF;
   assign delta  = biased[57:24];

   // Position step: clamp the difference to plus or minus max_step.
   assign jump = {opnd_ff[32], opnd_ff[32:0]};
   assign lim  = signed'({9'b0, max_step});
   always_comb begin
      priority if (jump > lim) begin
         clamped = lim;
      end else if (jump < -lim) begin
         clamped = -lim;
      end else begin
         clamped = jump;
      end
   end

   // Second stage: one shared adder with saturation to the 32-bit range.
   assign addend = vel_mode_ff ? delta : clamped;
   assign sum    = {{3{pos_ff[31]}}, pos_ff} + {addend[33], addend};

   always_comb begin
      priority if (sum > POS_MAX) begin
         new_pos = POS_MAX[31:0];
      end else if (sum < POS_MIN) begin
         new_pos = POS_MIN[31:0];
      end else begin
         new_pos = sum[31:0];
      end
   end

endmodule

### src/multi_joint_slew_limiter.sv
// Top level of the multi-joint slew limiter: joint state, sequencer and result register.
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_valid / req_ready     mode, joint, value, elapsed
//   rsp_      out        rsp_valid / rsp_ready     joint_out, position, last
//   csr_      in         csr_write_en              write_data (max_step)
//
// A write transaction is taken while the block is idle and gives no response.
// A tick walks the joints one at a time through the shared step unit, each joint passing
// through the states load, apply and send in that order.
// The request side is not ready from a tick's acceptance until its last response is taken.
// A stall on rsp_ready holds the walk at the current joint.
// Synchronous reset clears all joint state, velocity mode and max_step to its reset value.
`include "assert_macros.svh"

module multi_joint_slew_limiter #(
   parameter int unsigned NUM_JOINTS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic [mjsl_pkg::JOINT_W-1:0]         req_joint,
   input  logic signed [mjsl_pkg::VALUE_W-1:0]  req_value,
   input  logic [mjsl_pkg::ELAPSED_W-1:0]       req_elapsed,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mjsl_pkg::JOINT_W-1:0]         rsp_joint_out,
   output logic signed [mjsl_pkg::VALUE_W-1:0]  rsp_position,
   output logic                                 rsp_last,
   input  logic                                 csr_write_en,
   input  logic [mjsl_pkg::MAX_STEP_W-1:0]      csr_write_data
);

   localparam int unsigned IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_JOINTS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOAD  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;
   localparam logic [1:0] ST_SEND  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic signed [31:0] pos_ff  [NUM_JOINTS];
   logic signed [31:0] goal_ff [NUM_JOINTS];
   logic signed [31:0] vel_ff  [NUM_JOINTS];
   logic               vel_mode_ff;

   logic [mjsl_pkg::MAX_STEP_W-1:0] max_step_ff;
   logic [mjsl_pkg::ELAPSED_W-1:0]  elapsed_ff;

   logic [mjsl_pkg::JOINT_W-1:0] joint_out_ff;
   logic signed [31:0]           position_ff;
   logic                         last_ff;

   logic                    req_fire;
   logic                    rsp_fire;
   logic                    joint_ok;
   logic [IDX_W-1:0]        wr_idx;
   mjsl_pkg::step_ctrl_type step_ctrl;
   logic signed [31:0]      step_pos;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_SEND);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign joint_ok  = ({1'b0, req_joint} < 5'(NUM_JOINTS));
   assign wr_idx    = req_joint[IDX_W-1:0];

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff <= mjsl_pkg::MAX_STEP_RESET;
      end else if (csr_write_en) begin
         max_step_ff <= csr_write_data;
      end
   end

   // Sequencer over the joints of one tick.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_mode == mjsl_pkg::MODE_TICK)) begin
               state_in = ST_LOAD;
               idx_in   = '0;
            end
         end
         ST_LOAD: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_LOAD;
                  idx_in   = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // Elapsed time is held for the whole tick.
   always_ff @(posedge clock) begin
      if (req_fire && (req_mode == mjsl_pkg::MODE_TICK)) begin
         elapsed_ff <= req_elapsed;
      end
   end

   // Joint state: write transactions, and position write-back during a tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_JOINTS; i++) begin
            pos_ff[i]  <= '0;
            goal_ff[i] <= '0;
            vel_ff[i]  <= '0;
         end
         vel_mode_ff <= 1'b0;
      end else if (req_fire && joint_ok) begin
         unique case (req_mode)
            mjsl_pkg::MODE_TICK: begin
            end
            mjsl_pkg::MODE_GOAL: begin
               goal_ff[wr_idx] <= req_value;
               vel_mode_ff     <= 1'b0;
            end
            mjsl_pkg::MODE_POS_GOAL: begin
               goal_ff[wr_idx] <= req_value;
               pos_ff[wr_idx]  <= req_value;
               vel_mode_ff     <= 1'b0;
            end
            mjsl_pkg::MODE_VEL: begin
               vel_ff[wr_idx] <= req_value;
               vel_mode_ff    <= 1'b1;
            end
            default: begin
            end
         endcase
      end else if (state_ff == ST_APPLY) begin
         pos_ff[idx_ff] <= step_pos;
      end
   end

   // Shared step unit.
   assign step_ctrl.load     = (state_ff == ST_LOAD);
   assign step_ctrl.vel_mode = vel_mode_ff;

   mjsl_step_unit u_step (
      .clock    (clock),
      .ctrl     (step_ctrl),
      .pos      (pos_ff[idx_ff]),
      .goal     (goal_ff[idx_ff]),
      .vel      (vel_ff[idx_ff]),
      .elapsed  (elapsed_ff),
      .max_step (max_step_ff),
      .new_pos  (step_pos)
   );

   // Response register, loaded as each joint's position is written back.
   always_ff @(posedge clock) begin
      if (state_ff == ST_APPLY) begin
         joint_out_ff <= mjsl_pkg::JOINT_W'(idx_ff);
         position_ff  <= step_pos;
         last_ff      <= (idx_ff == LAST_IDX);
      end
   end

   assign rsp_joint_out = joint_out_ff;
   assign rsp_position  = position_ff;
   assign rsp_last      = last_ff;

   // Checks on the sequencer.
   `ASSERT_SAME(a_no_req_during_tick, rsp_valid, !req_ready, "request taken during a tick")
   `ASSERT_NEXT(a_idle_after_last, rsp_fire && rsp_last, req_ready, "not idle after last response")
   `ASSERT_SAME(a_last_joint, rsp_valid && rsp_last,
                rsp_joint_out == mjsl_pkg::JOINT_W'(NUM_JOINTS - 1), "last mark on wrong joint")
   `ASSERT_NEXT(a_tick_starts_walk, req_fire && (req_mode == mjsl_pkg::MODE_TICK),
                !req_ready && !rsp_valid, "tick did not start the joint walk")

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the multi-joint slew limiter, with its own joint predictor.
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned NUM_JOINTS      = 8;
   localparam int unsigned SETTLE_CYCLES   = 3 * NUM_JOINTS + 8;
   localparam int unsigned WATCHDOG_LIMIT  = 4000;
   localparam int unsigned RSP_HOLD_CYCLES = 400;
   localparam int unsigned MAX_PRINTED     = 40;
   localparam int unsigned PHASE_ITEMS     = 85;

   localparam logic signed [mjsl_pkg::VALUE_W-1:0] POS_MAX     = 32'sh7FFFFFFF;
   localparam logic signed [mjsl_pkg::VALUE_W-1:0] POS_MIN     = 32'sh80000000;
   localparam logic [mjsl_pkg::MAX_STEP_W-1:0]     STEP_ONE    = 25'd16777216;
   localparam logic [mjsl_pkg::MAX_STEP_W-1:0]     STEP_FULL   = 25'h1FFFFFF;
   localparam logic [mjsl_pkg::ELAPSED_W-1:0]      HALF_SECOND = 24'h800000;
   localparam logic [mjsl_pkg::ELAPSED_W-1:0]      ELAPSED_MAX = 24'hFFFFFF;

   // Receiver stall styles.
   typedef enum int unsigned {
      RSP_ALWAYS,
      RSP_LIGHT,
      RSP_HEAVY,
      RSP_EVERY_THIRD
   } rsp_style_type;

   // One reported joint position as the block should emit it.
   typedef struct {
      logic [mjsl_pkg::JOINT_W-1:0]        joint;
      logic signed [mjsl_pkg::VALUE_W-1:0] position;
      logic                                last;
   } joint_report_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic [1:0]                            req_mode;
   logic [mjsl_pkg::JOINT_W-1:0]          req_joint;
   logic signed [mjsl_pkg::VALUE_W-1:0]   req_value;
   logic [mjsl_pkg::ELAPSED_W-1:0]        req_elapsed;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic [mjsl_pkg::JOINT_W-1:0]          rsp_joint_out;
   logic signed [mjsl_pkg::VALUE_W-1:0]   rsp_position;
   logic                                  rsp_last;
   logic                                  csr_write_en;
   logic [mjsl_pkg::MAX_STEP_W-1:0]       csr_write_data;

   // Predicted joint state and the step limit currently programmed.
   logic signed [mjsl_pkg::VALUE_W-1:0]   joint_pos [NUM_JOINTS];
   logic signed [mjsl_pkg::VALUE_W-1:0]   joint_goal [NUM_JOINTS];
   logic signed [mjsl_pkg::VALUE_W-1:0]   joint_vel [NUM_JOINTS];
   bit                                    vel_mode_on;
   logic [mjsl_pkg::MAX_STEP_W-1:0]       step_limit;
   joint_report_type                      expected_reports [$];

   int unsigned                           mismatch_count;
   int unsigned                           quiet_cycles;
   int unsigned                           burst_left;
   bit                                    hold_rsp_request;

   multi_joint_slew_limiter #(
      .NUM_JOINTS(NUM_JOINTS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_joint     (req_joint),
      .req_value     (req_value),
      .req_elapsed   (req_elapsed),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_joint_out (rsp_joint_out),
      .rsp_position  (rsp_position),
      .rsp_last      (rsp_last),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Saturate a wide sum to the signed 32-bit position range.
   function automatic logic signed [mjsl_pkg::VALUE_W-1:0] clamp_position(input longint sum);
      if (sum > longint'(POS_MAX)) return POS_MAX;
      if (sum < longint'(POS_MIN)) return POS_MIN;
      return sum[mjsl_pkg::VALUE_W-1:0];
   endfunction

   // Position mode: move toward the goal by at most the programmed step.
   function automatic logic signed [mjsl_pkg::VALUE_W-1:0] slew_toward_goal(
         input logic signed [mjsl_pkg::VALUE_W-1:0] pos,
         input logic signed [mjsl_pkg::VALUE_W-1:0] goal);
      longint jump;
      longint lim;
      jump = longint'(goal) - longint'(pos);
      lim  = longint'(step_limit);
      if (jump > lim) jump = lim;
      if (jump < -lim) jump = -lim;
      return clamp_position(longint'(pos) + jump);
   endfunction

   // Velocity mode: add elapsed * velocity, rounded to nearest with ties upward.
   function automatic logic signed [mjsl_pkg::VALUE_W-1:0] integrate_velocity(
         input logic signed [mjsl_pkg::VALUE_W-1:0] pos,
         input logic signed [mjsl_pkg::VALUE_W-1:0] vel,
         input logic [mjsl_pkg::ELAPSED_W-1:0] elapsed);
      longint product;
      longint delta;
      product = longint'(elapsed) * longint'(vel);
      delta   = (product + 64'sd8388608) >>> 24;
      return clamp_position(longint'(pos) + delta);
   endfunction

   // Update the predicted state for one accepted transaction and queue any reports.
   task automatic apply_request(input logic [1:0] mode,
         input logic [mjsl_pkg::JOINT_W-1:0] joint,
         input logic signed [mjsl_pkg::VALUE_W-1:0] value,
         input logic [mjsl_pkg::ELAPSED_W-1:0] elapsed);
      joint_report_type rpt;
      if (mode == mjsl_pkg::MODE_TICK) begin
         for (int j = 0; j < NUM_JOINTS; j++) begin
            if (vel_mode_on)
               joint_pos[j] = integrate_velocity(joint_pos[j], joint_vel[j], elapsed);
            else
               joint_pos[j] = slew_toward_goal(joint_pos[j], joint_goal[j]);
            rpt.joint    = mjsl_pkg::JOINT_W'(j);
            rpt.position = joint_pos[j];
            rpt.last     = (j == NUM_JOINTS - 1);
            expected_reports = {expected_reports, rpt};
         end
      end else if (joint < NUM_JOINTS) begin
         case (mode)
            mjsl_pkg::MODE_GOAL: begin
               joint_goal[joint] = value;
               vel_mode_on = 1'b0;
            end
            mjsl_pkg::MODE_POS_GOAL: begin
               joint_goal[joint] = value;
               joint_pos[joint]  = value;
               vel_mode_on = 1'b0;
            end
            default: begin
               joint_vel[joint] = value;
               vel_mode_on = 1'b1;
            end
         endcase
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // Predict from every accepted request transaction.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         apply_request(req_mode, req_joint, req_value, req_elapsed);
   end

   // Compare every accepted response transaction with the oldest expected report.
   always @(posedge clock) begin : check_responses
      joint_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("response with no tick pending, joint", rsp_joint_out, -1);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_joint_out !== want.joint)
               report_mismatch("joint_out", rsp_joint_out, want.joint);
            if (rsp_position !== want.position)
               report_mismatch("position", longint'(rsp_position), longint'(want.position));
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // End the run if no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response ready follows changing stall styles, with a long hold-off on request.
   initial begin : rsp_stall_pattern
      rsp_style_type style;
      int unsigned   style_left;
      int unsigned   beat;
      rsp_ready  = 1'b0;
      style      = RSP_ALWAYS;
      style_left = 0;
      beat       = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (style_left == 0) begin
               style      = rsp_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(8, 80);
            end
            style_left--;
            beat++;
            case (style)
               RSP_ALWAYS:  rsp_ready <= 1'b1;
               RSP_LIGHT:   rsp_ready <= ($urandom_range(0, 3) != 0);
               RSP_HEAVY:   rsp_ready <= ($urandom_range(0, 1) != 0);
               default:     rsp_ready <= (beat % 3 == 0);
            endcase
         end
      end
   end

   // Offer one request transaction in bursts with random gaps, and wait for its acceptance.
   task automatic send_request(input logic [1:0] mode,
         input logic [mjsl_pkg::JOINT_W-1:0] joint,
         input logic signed [mjsl_pkg::VALUE_W-1:0] value,
         input logic [mjsl_pkg::ELAPSED_W-1:0] elapsed);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_joint   <= joint;
      req_value   <= value;
      req_elapsed <= elapsed;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Stop offering, then wait for all reports and for the block to settle.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Program max_step; only called while the block is idle.
   task automatic write_max_step(input logic [mjsl_pkg::MAX_STEP_W-1:0] limit);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= limit;
      @(negedge clock);
      csr_write_en <= 1'b0;
      step_limit = limit;
   endtask

   // Values biased toward the extremes and toward moves near the step size.
   function automatic logic signed [mjsl_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return POS_MAX;
         1:       return POS_MIN;
         2:       return ($urandom_range(0, 1) == 0) ? 32'sd0 : -32'sd1;
         3, 4, 5: return $signed(32'($urandom_range(0, 33554432))) - 32'sd16777216;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [mjsl_pkg::ELAPSED_W-1:0] pick_elapsed();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ELAPSED_MAX;
         2, 3, 4: return mjsl_pkg::ELAPSED_W'($urandom_range(0, 65536));
         default: return mjsl_pkg::ELAPSED_W'($urandom);
      endcase
   endfunction

   task automatic send_tick(input logic [mjsl_pkg::ELAPSED_W-1:0] elapsed);
      send_request(mjsl_pkg::MODE_TICK, mjsl_pkg::JOINT_W'($urandom), $urandom, elapsed);
   endtask

   // A few writes of one kind followed by a tick; now and then a stray write.
   task automatic send_random_sequence(output int unsigned counted);
      int unsigned writes;
      bit          vel_style;
      logic [1:0]  mode_sel;
      counted = 0;
      if ($urandom_range(0, 9) == 0) begin
         // A write to a joint that does not exist is ignored by the block.
         mode_sel = 2'($urandom_range(1, 3));
         send_request(mode_sel, mjsl_pkg::JOINT_W'($urandom_range(NUM_JOINTS, 15)),
                      $urandom, pick_elapsed());
      end else begin
         writes    = $urandom_range(0, 4);
         vel_style = ($urandom_range(0, 2) == 0);
         repeat (writes) begin
            // One write in ten breaks the sequence with the other kind.
            if (vel_style ^ ($urandom_range(0, 9) == 0))
               mode_sel = mjsl_pkg::MODE_VEL;
            else
               mode_sel = ($urandom_range(0, 2) == 0) ? mjsl_pkg::MODE_POS_GOAL
                                                      : mjsl_pkg::MODE_GOAL;
            send_request(mode_sel, mjsl_pkg::JOINT_W'($urandom_range(0, NUM_JOINTS - 1)),
                         pick_value(), pick_elapsed());
         end
         send_tick(pick_elapsed());
         counted = writes + 1;
      end
   endtask

   // A tick right after reset reports all joints at zero.
   task automatic test_reset_state();
      send_tick(pick_elapsed());
   endtask

   // Position mode at the goal extremes and at every step limit extreme.
   task automatic test_goal_slew();
      send_request(mjsl_pkg::MODE_POS_GOAL, 0, POS_MAX, '0);
      send_request(mjsl_pkg::MODE_GOAL, 0, POS_MIN, '0);
      send_request(mjsl_pkg::MODE_POS_GOAL, 1, POS_MIN, '0);
      send_request(mjsl_pkg::MODE_GOAL, 1, POS_MAX, '0);
      send_request(mjsl_pkg::MODE_GOAL, 3, -32'sd16777, '0);
      send_request(mjsl_pkg::MODE_GOAL, 7, -32'sd16778, ELAPSED_MAX);
      send_tick(ELAPSED_MAX);
      wait_until_idle();
      write_max_step('0);
      send_tick(pick_elapsed());
      wait_until_idle();
      write_max_step(STEP_FULL);
      send_tick(pick_elapsed());
      wait_until_idle();
      write_max_step(STEP_ONE);
      send_tick(pick_elapsed());
   endtask

   // Writes to joints past the last one change nothing, velocity mode included.
   task automatic test_ignored_joints();
      send_request(mjsl_pkg::MODE_VEL, mjsl_pkg::JOINT_W'(NUM_JOINTS), POS_MAX, '0);
      send_request(mjsl_pkg::MODE_GOAL, 15, POS_MIN, '0);
      send_request(mjsl_pkg::MODE_POS_GOAL, mjsl_pkg::JOINT_W'(NUM_JOINTS + 1), -32'sd1, '0);
      send_tick(ELAPSED_MAX);
   endtask

   // Velocity mode: saturation at both ends and the rounding tie.
   task automatic test_velocity_mode();
      send_request(mjsl_pkg::MODE_POS_GOAL, 0, 32'sh7FFF0000, '0);
      send_request(mjsl_pkg::MODE_POS_GOAL, 1, 32'sh80010000, '0);
      send_request(mjsl_pkg::MODE_VEL, 0, POS_MAX, '0);
      send_request(mjsl_pkg::MODE_VEL, 1, POS_MIN, '0);
      send_request(mjsl_pkg::MODE_VEL, 2, 32'sd1, '0);
      send_request(mjsl_pkg::MODE_VEL, 3, -32'sd1, '0);
      send_request(mjsl_pkg::MODE_VEL, 4, 32'sd3, '0);
      send_tick(HALF_SECOND);
      send_tick(ELAPSED_MAX);
      send_tick('0);
   endtask

   // A goal write drops the block back into position mode.
   task automatic test_mode_return();
      send_request(mjsl_pkg::MODE_GOAL, 5, pick_value(), '0);
      send_tick(ELAPSED_MAX);
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_output_backpressure();
      int unsigned counted;
      int unsigned total;
      wait_until_idle();
      write_max_step(mjsl_pkg::MAX_STEP_W'($urandom_range(1, 1 << 20)));
      hold_rsp_request = 1'b1;
      total = 0;
      while (total < 40) begin
         send_random_sequence(counted);
         total += counted;
      end
   endtask

   // Random sequences under several step limits, the extremes among them.
   task automatic test_random_traffic();
      logic [mjsl_pkg::MAX_STEP_W-1:0] limits [5];
      int unsigned                     counted;
      int unsigned                     total;
      limits = '{mjsl_pkg::MAX_STEP_W'($urandom_range(1, 16777216)), '0, STEP_FULL,
                 STEP_ONE, mjsl_pkg::MAX_STEP_W'($urandom_range(1, 4096))};
      foreach (limits[p]) begin
         wait_until_idle();
         write_max_step(limits[p]);
         total = 0;
         while (total < PHASE_ITEMS) begin
            send_random_sequence(counted);
            total += counted;
         end
      end
   endtask

   // Reset, run the tests in turn, then drain and give the verdict.
   initial begin : run_tests
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = mjsl_pkg::MODE_TICK;
      req_joint        = '0;
      req_value        = '0;
      req_elapsed      = '0;
      csr_write_en     = 1'b0;
      csr_write_data   = '0;
      burst_left       = 0;
      hold_rsp_request = 1'b0;
      mismatch_count   = 0;
      quiet_cycles     = 0;
      foreach (joint_pos[j]) begin
         joint_pos[j]  = '0;
         joint_goal[j] = '0;
         joint_vel[j]  = '0;
      end
      vel_mode_on = 1'b0;
      step_limit  = mjsl_pkg::MAX_STEP_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_goal_slew();
      test_ignored_joints();
      test_velocity_mode();
      test_mode_return();
      test_output_backpressure();
      test_random_traffic();

      wait_until_idle();
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/mjsl_pkg.sv
src/mjsl_step_unit.sv
src/multi_joint_slew_limiter.sv
tb/sv/tb_top.sv
